[hw/rtl/rkd_pkg.sv]
// ----------------------------------------------------------------------------
// Rotary knob decoder package
// Shared types and constants for the dual rotary knob decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rkd_pkg;

  // Direction counter slots
  localparam logic [1:0] CntLeftUp    = 2'd0;
  localparam logic [1:0] CntLeftDown  = 2'd1;
  localparam logic [1:0] CntRightUp   = 2'd2;
  localparam logic [1:0] CntRightDown = 2'd3;

  // Guard mark codes
  localparam logic [1:0] GuardIdle  = 2'd0;
  localparam logic [1:0] GuardLine1 = 2'd1;
  localparam logic [1:0] GuardLine2 = 2'd2;
  localparam logic [1:0] GuardFirst = 2'd3;

  // Both-edge history patterns
  localparam logic [7:0] PatDown0 = 8'h04;
  localparam logic [7:0] PatDown1 = 8'h45;
  localparam logic [7:0] PatDown2 = 8'h51;
  localparam logic [7:0] PatDown3 = 8'h10;
  localparam logic [7:0] PatUp0   = 8'h01;
  localparam logic [7:0] PatUp1   = 8'h15;
  localparam logic [7:0] PatUp2   = 8'h54;
  localparam logic [7:0] PatUp3   = 8'h40;

  // One edge event
  typedef struct packed {
    logic knob_side;
    logic edge_line;
    logic level_a;
    logic level_b;
  } rkd_item_t;

  // Decoder state, index 0 is the left knob, 1 the right knob
  typedef struct packed {
    logic [1:0][7:0] hist;
    logic [1:0][1:0] guard;
    logic [3:0][1:0] cnt;
  } rkd_state_t;

endpackage

`default_nettype wire

[hw/rtl/rkd_in_if.sv]
// ----------------------------------------------------------------------------
// Rotary knob event channel
// Valid/ready channel carrying one knob edge event.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkd_in_if;
  logic valid;
  logic ready;
  logic knob_side;
  logic edge_line;
  logic level_a;
  logic level_b;

  modport source (
    output valid, knob_side, edge_line, level_a, level_b,
    input  ready
  );
  modport sink (
    input  valid, knob_side, edge_line, level_a, level_b,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/rkd_out_if.sv]
// ----------------------------------------------------------------------------
// Rotary knob result channel
// Valid/ready channel carrying one direction event mask.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_mask;

  modport source (
    output valid, event_mask,
    input  ready
  );
  modport sink (
    input  valid, event_mask,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/dual_rotary_knob_decoder_core.sv]
// ----------------------------------------------------------------------------
// Dual rotary knob decoder core
// Decodes edge events of two quadrature knobs into direction event masks.
// ----------------------------------------------------------------------------
// Path: an event passes through the input register, then the result
//   register; events that give no mask produce nothing.
// Throughput: one event per cycle while the result channel does not stall,
//   set by the single decode pass that reads and writes the knob state in the same cycle.
// Reset: histories, guard marks, counters and mode clear to zero; both
//   pipeline stages come up empty.
`default_nettype none

module dual_rotary_knob_decoder_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  rkd_in_if.sink     in_i,
  rkd_out_if.source  out_o
);

  logic                mode_q;
  rkd_pkg::rkd_item_t  item_q;
  logic                item_vld_q;
  rkd_pkg::rkd_state_t state_q;
  rkd_pkg::rkd_state_t state_d;
  logic [3:0]          mask_q;
  logic [3:0]          mask_d;
  logic                out_vld_q;
  logic                advance;
  logic                in_xfer;

  // Decode the held event when the result register can take its output.
  assign advance  = item_vld_q && (!out_vld_q || out_o.ready);
  // Take a new event whenever the input register empties this cycle.
  assign in_i.ready = !item_vld_q || advance;
  assign in_xfer  = in_i.valid && in_i.ready;

  assign out_o.valid      = out_vld_q;
  assign out_o.event_mask = mask_q;

  rkd_decode u_decode (
    .mode_i  (mode_q),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .mask_o  (mask_d)
  );

  // Mode register: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input stage: hold the event until the decode pass consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= '{knob_side: in_i.knob_side, edge_line: in_i.edge_line,
                  level_a: in_i.level_a, level_b: in_i.level_b};
    end
  end

  // Knob state: advance once per decoded event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result stage: load a nonzero mask, drop it once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= (mask_d != 4'd0);
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mask_q <= mask_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rkd_decode.sv]
// ----------------------------------------------------------------------------
// Rotary knob step decoder
// Combinational next-state and event mask for one edge event.
// ----------------------------------------------------------------------------
`default_nettype none

module rkd_decode (
  input  logic               mode_i,
  input  rkd_pkg::rkd_item_t item_i,
  input  rkd_pkg::rkd_state_t state_i,
  output rkd_pkg::rkd_state_t state_o,
  output logic [3:0]         mask_o
);

  always_comb begin
    rkd_pkg::rkd_state_t st;
    logic       side;
    logic [7:0] hist_new;
    logic       wrong;
    logic       other;
    logic       is_down;
    logic [1:0] line_code;
    logic [1:0] up_idx;
    logic [1:0] dn_idx;
    logic       bump_en;
    logic [1:0] bump_idx;
    logic [1:0] bump_opp;
    logic [1:0] bump_amt;
    logic       drain;

    st        = state_i;
    mask_o    = 4'd0;
    side      = item_i.knob_side;
    up_idx    = side ? rkd_pkg::CntRightUp   : rkd_pkg::CntLeftUp;
    dn_idx    = side ? rkd_pkg::CntRightDown : rkd_pkg::CntLeftDown;
    line_code = item_i.edge_line ? rkd_pkg::GuardLine2 : rkd_pkg::GuardLine1;
    bump_en   = 1'b0;
    bump_idx  = up_idx;
    bump_opp  = dn_idx;
    bump_amt  = 2'd1;
    drain     = 1'b1;
    is_down   = 1'b0;

    // shift in the new sample pair
    hist_new = {state_i.hist[side][3:0], 1'b0, item_i.level_a, 1'b0, item_i.level_b};
    st.hist[side] = hist_new;

    wrong = item_i.edge_line ? item_i.level_b : !item_i.level_a;
    other = item_i.edge_line ? item_i.level_a : item_i.level_b;

    if (mode_i) begin
      if (wrong) begin
        st.guard[side] = (state_i.guard[side] == rkd_pkg::GuardIdle) ?
                         rkd_pkg::GuardFirst : line_code;
        drain = 1'b0;
      end else if (state_i.guard[side] == line_code) begin
        st.guard[side] = rkd_pkg::GuardIdle;
        drain = 1'b0;
      end else begin
        st.guard[side] = rkd_pkg::GuardIdle;
        // right knob runs with swapped sense
        is_down  = side ? other : !other;
        bump_en  = 1'b1;
        bump_amt = 2'd2;
        bump_idx = is_down ? dn_idx : up_idx;
        bump_opp = is_down ? up_idx : dn_idx;
      end
    end else begin
      if (hist_new inside {rkd_pkg::PatDown0, rkd_pkg::PatDown1,
                           rkd_pkg::PatDown2, rkd_pkg::PatDown3}) begin
        bump_en  = 1'b1;
        bump_idx = side ? up_idx : dn_idx;
        bump_opp = side ? dn_idx : up_idx;
      end else if (hist_new inside {rkd_pkg::PatUp0, rkd_pkg::PatUp1,
                                    rkd_pkg::PatUp2, rkd_pkg::PatUp3}) begin
        bump_en  = 1'b1;
        bump_idx = side ? dn_idx : up_idx;
        bump_opp = side ? up_idx : dn_idx;
      end
    end

    if (bump_en) begin
      st.cnt[bump_idx] = st.cnt[bump_idx] + bump_amt;
      st.cnt[bump_opp] = 2'd0;
    end

    // drain every counter that reached two
    if (drain) begin
      for (int k = 0; k < 4; k++) begin
        if (st.cnt[k][1]) begin
          mask_o[k]    = 1'b1;
          st.cnt[k][1] = 1'b0;
        end
      end
    end

    state_o = st;
  end

endmodule

`default_nettype wire

[test/dual_rotary_knob_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual rotary knob decoder core testbench
// Drives knob edge events through the input channel and checks every event
// mask on the result channel against an in-bench decoder of both knobs.
// Runs directed steps in both decoding modes, then random quadrature walks
// mixed with bounces and noise, under several sender and receiver idle
// profiles, with mode writes only while the core is idle.
// ----------------------------------------------------------------------------

module dual_rotary_knob_decoder_core_tb;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Configuration port, written only from the sequencer below
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  // Source side of the event channel and sink side of the result channel
  logic               src_valid = 1'b0;
  rkd_pkg::rkd_item_t src_item  = '0;
  logic               sink_ready = 1'b0;

  // Idle profile, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  rkd_pkg::rkd_item_t pending_events[$];
  logic [3:0]         expected_masks[$];
  int unsigned errors = 0;

  // Decoder copy: mode, per-knob history and guard, four direction counters
  logic       guarded_mode = 1'b0;
  logic [7:0] knob_hist  [2] = '{8'h00, 8'h00};
  logic [1:0] knob_guard [2] = '{rkd_pkg::GuardIdle, rkd_pkg::GuardIdle};
  logic [1:0] step_cnt   [4] = '{2'd0, 2'd0, 2'd0, 2'd0};

  // Quadrature walk position and heading for each knob
  int unsigned        walk_pos [2] = '{0, 0};
  bit                 walk_down[2] = '{1'b1, 1'b0};
  rkd_pkg::rkd_item_t last_pushed = '0;

  rkd_in_if  in_if ();
  rkd_out_if out_if ();

  assign in_if.valid     = src_valid;
  assign in_if.knob_side = src_item.knob_side;
  assign in_if.edge_line = src_item.edge_line;
  assign in_if.level_a   = src_item.level_a;
  assign in_if.level_b   = src_item.level_b;
  assign out_if.ready    = sink_ready;

  dual_rotary_knob_decoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Add to one direction counter, kept to 2 bits, and clear its opposite.
  function automatic void bump_counter(input logic [1:0] idx, input logic [1:0] opp,
                                       input logic [1:0] amount);
    step_cnt[idx] = step_cnt[idx] + amount;
    step_cnt[opp] = 2'd0;
  endfunction

  // Decode one transferred event; return the mask and flag whether it is emitted.
  function automatic logic [3:0] decode_event(input rkd_pkg::rkd_item_t ev,
                                              output logic hit);
    int         side;
    logic [1:0] line_code;
    logic [1:0] up_idx;
    logic [1:0] down_idx;
    logic       wrong_level;
    logic       other_level;
    logic       is_down;
    logic [3:0] mask;
    side      = ev.knob_side;
    line_code = ev.edge_line ? rkd_pkg::GuardLine2 : rkd_pkg::GuardLine1;
    up_idx    = ev.knob_side ? rkd_pkg::CntRightUp : rkd_pkg::CntLeftUp;
    down_idx  = ev.knob_side ? rkd_pkg::CntRightDown : rkd_pkg::CntLeftDown;
    hit       = 1'b0;
    mask      = 4'd0;
    knob_hist[side] = {knob_hist[side][3:0], 1'b0, ev.level_a, 1'b0, ev.level_b};
    if (guarded_mode) begin
      wrong_level = ev.edge_line ? ev.level_b : !ev.level_a;
      other_level = ev.edge_line ? ev.level_a : ev.level_b;
      // Wrong level: mark the guard and reject without a drain pass
      if (wrong_level) begin
        knob_guard[side] = (knob_guard[side] == rkd_pkg::GuardIdle) ?
                           rkd_pkg::GuardFirst : line_code;
        return mask;
      end
      // Same line again after a rejection: clear the guard and reject
      if (knob_guard[side] == line_code) begin
        knob_guard[side] = rkd_pkg::GuardIdle;
        return mask;
      end
      knob_guard[side] = rkd_pkg::GuardIdle;
      // Right knob has its direction sense swapped
      is_down = ev.knob_side ? other_level : !other_level;
      if (is_down) begin
        bump_counter(down_idx, up_idx, 2'd2);
      end else begin
        bump_counter(up_idx, down_idx, 2'd2);
      end
    end else begin
      if (knob_hist[side] inside {rkd_pkg::PatDown0, rkd_pkg::PatDown1,
                                  rkd_pkg::PatDown2, rkd_pkg::PatDown3}) begin
        if (ev.knob_side) bump_counter(up_idx, down_idx, 2'd1);
        else bump_counter(down_idx, up_idx, 2'd1);
      end else if (knob_hist[side] inside {rkd_pkg::PatUp0, rkd_pkg::PatUp1,
                                           rkd_pkg::PatUp2, rkd_pkg::PatUp3}) begin
        if (ev.knob_side) bump_counter(down_idx, up_idx, 2'd1);
        else bump_counter(up_idx, down_idx, 2'd1);
      end
    end
    // Drain every counter that reached a full step
    for (int k = 0; k < 4; k++) begin
      if (step_cnt[k] >= 2'd2) begin
        mask[k]     = 1'b1;
        step_cnt[k] = step_cnt[k] - 2'd2;
      end
    end
    hit = (mask != 4'd0);
    return mask;
  endfunction

  function automatic void report_error(input string what, input logic [3:0] exp_mask,
                                       input logic [3:0] act_mask);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected mask %b, got %b", $realtime, what, exp_mask, act_mask);
    end
  endfunction

  // Driver: advance to the next pending event once the current one has
  // transferred, or drop valid for an idle cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else if (!src_valid || in_if.ready) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        src_item  <= pending_events.pop_front();
        src_valid <= 1'b1;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random per the active profile.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check result transfers first, then track the mode and predict
  // from event transfers, so an expectation is never consumed in its own cycle.
  always @(posedge clk_i) begin
    logic [3:0] exp_mask;
    logic [3:0] new_mask;
    logic       new_hit;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_masks.size() == 0) begin
          report_error("unexpected result", 4'd0, out_if.event_mask);
        end else begin
          exp_mask = expected_masks.pop_front();
          if (out_if.event_mask !== exp_mask) begin
            report_error("event_mask mismatch", exp_mask, out_if.event_mask);
          end
        end
      end
      if (cfg_we) begin
        guarded_mode = cfg_wdata;
      end
      if (in_if.valid && in_if.ready) begin
        new_mask = decode_event(src_item, new_hit);
        if (new_hit) begin
          expected_masks.push_back(new_mask);
        end
      end
    end
  end

  task automatic push_event(input bit side, input bit line, input bit a, input bit b);
    rkd_pkg::rkd_item_t ev;
    ev.knob_side = side;
    ev.edge_line = line;
    ev.level_a   = a;
    ev.level_b   = b;
    pending_events.push_back(ev);
    last_pushed = ev;
  endtask

  // Queue random traffic: mostly quadrature walks, some bounces and noise.
  task automatic push_walk(input int unsigned count);
    int unsigned roll;
    int unsigned side;
    int unsigned old_pos;
    bit          line;
    bit          a;
    bit          b;
    side = $urandom_range(1);
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        push_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (roll < 25) begin
        // Bounce: repeat the last event as is
        pending_events.push_back(last_pushed);
      end else begin
        if ($urandom_range(99) < 20) side = 1 - side;
        if ($urandom_range(99) < 10) walk_down[side] = !walk_down[side];
        old_pos = walk_pos[side];
        walk_pos[side] = walk_down[side] ? (old_pos + 1) % 4 : (old_pos + 3) % 4;
        // Gray order 00, 10, 11, 01 in (a, b); line two fires when b moves
        a = (walk_pos[side] == 1) || (walk_pos[side] == 2);
        b = (walk_pos[side] == 2) || (walk_pos[side] == 3);
        line = ((old_pos == 1 && walk_pos[side] == 2) ||
                (old_pos == 2 && walk_pos[side] == 1) ||
                (old_pos == 3 && walk_pos[side] == 0) ||
                (old_pos == 0 && walk_pos[side] == 3));
        push_event(1'(side), line, a, b);
      end
    end
  endtask

  // Hold until every event has transferred and every mask has arrived,
  // then let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_events.size() != 0 || src_valid || expected_masks.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    @(posedge clk_i);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  // Sequencer
  initial begin
    int unsigned send_profile  [4];
    int unsigned stall_profile [4];
    send_profile  = '{0, 76, 0, 21};
    stall_profile = '{0, 0, 76, 21};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Both-edge mode out of reset: a full down turn of the left knob, then
    // two up-pattern edges of the right knob, which count down, and an unmatched jump
    push_event(1'b0, 1'b0, 1'b1, 1'b0);
    push_event(1'b0, 1'b1, 1'b1, 1'b1);
    push_event(1'b0, 1'b0, 1'b0, 1'b1);
    push_event(1'b0, 1'b1, 1'b0, 1'b0);
    push_event(1'b1, 1'b1, 1'b0, 1'b1);
    push_event(1'b1, 1'b0, 1'b1, 1'b1);
    push_event(1'b0, 1'b0, 1'b1, 1'b1);
    wait_drained();

    write_mode(1'b1);
    // Single-edge mode: wrong level on each line, a same-line repeat, a first
    // rejection followed by an accept, then both directions on both knobs
    push_event(1'b0, 1'b0, 1'b0, 1'b0);
    push_event(1'b0, 1'b1, 1'b0, 1'b1);
    push_event(1'b0, 1'b1, 1'b0, 1'b0);
    push_event(1'b0, 1'b0, 1'b0, 1'b1);
    push_event(1'b0, 1'b0, 1'b1, 1'b0);
    push_event(1'b0, 1'b0, 1'b1, 1'b1);
    push_event(1'b0, 1'b1, 1'b0, 1'b0);
    push_event(1'b0, 1'b1, 1'b1, 1'b0);
    push_event(1'b1, 1'b0, 1'b1, 1'b1);
    push_event(1'b1, 1'b0, 1'b1, 1'b0);
    push_event(1'b1, 1'b1, 1'b1, 1'b0);
    push_event(1'b1, 1'b1, 1'b0, 1'b0);
    push_event(1'b1, 1'b1, 1'b1, 1'b1);
    push_event(1'b1, 1'b1, 1'b0, 1'b0);
    wait_drained();

    // Random phases: alternate the mode, step through the idle profiles, and
    // pause the sender mid-phase until every mask has come back
    for (int p = 0; p < 8; p++) begin
      write_mode(p[0]);
      set_idling(send_profile[p / 2], stall_profile[p / 2]);
      push_walk(95);
      wait_drained();
      push_walk(95);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    errors += expected_masks.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
